// ===== sv/psg_pkg.sv =====
// shared types, constants and level table of the four voice sound generator
`default_nettype none

package psg_pkg;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   localparam int NUM_TONES = 3;

   typedef logic [9:0]         period_type;
   typedef logic [3:0]         atten_type;
   typedef logic signed [13:0] level_type;
   typedef logic [14:0]        lfsr_type;

   localparam period_type PERIOD_DC_LO = 10'd1;
   localparam period_type PERIOD_DC_HI = 10'd16;
   localparam lfsr_type   LFSR_SEED    = 15'h4000;
   localparam atten_type  ATTEN_SILENT = 4'hf;
   localparam logic [1:0] VOICE_NOISE  = 2'd3;
   localparam logic [1:0] RATE_TONE2   = 2'd3;
   localparam period_type NOISE_BASE   = 10'h010;

   typedef struct packed {
      logic [3:0][3:0] atten;
      logic [2:0][9:0] period;
      logic [2:0]      noise_ctl;
   } regs_type;

   function automatic level_type level_of(input atten_type a);
      level_type lv;
      case (a)
         4'd0:    lv = 14'sd4096;
         4'd1:    lv = 14'sd3162;
         4'd2:    lv = 14'sd2546;
         4'd3:    lv = 14'sd1986;
         4'd4:    lv = 14'sd1564;
         4'd5:    lv = 14'sd1186;
         4'd6:    lv = 14'sd936;
         4'd7:    lv = 14'sd712;
         4'd8:    lv = 14'sd540;
         4'd9:    lv = 14'sd392;
         4'd10:   lv = 14'sd294;
         4'd11:   lv = 14'sd208;
         4'd12:   lv = 14'sd140;
         4'd13:   lv = 14'sd76;
         4'd14:   lv = 14'sd36;
         default: lv = 14'sd0;
      endcase
      return lv;
   endfunction

endpackage

`default_nettype wire

// ===== sv/psg_regs.sv =====
// register file written by the latch/data byte protocol
`default_nettype none

module psg_regs
   import psg_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       wr,
   input  wire logic [7:0] data,
   output regs_type        regs,
   output logic            reseed
);

   logic [7:0] latch_ff, latch_in;
   regs_type   regs_ff, regs_in;
   logic [1:0] voice;

   always_comb begin
      latch_in = latch_ff;
      regs_in  = regs_ff;
      reseed   = 1'b0;
      if (data[7]) begin
         latch_in = data;
      end
      voice = latch_in[6:5];
      if (wr) begin
         if (latch_in[4]) begin
            regs_in.atten[voice] = data[3:0];
         end else if (voice != VOICE_NOISE) begin
            if (data[7]) begin
               regs_in.period[voice] = {regs_ff.period[voice][9:4], data[3:0]};
            end else begin
               regs_in.period[voice] = {data[5:0], regs_ff.period[voice][3:0]};
            end
         end else begin
            regs_in.noise_ctl = data[2:0];
            reseed            = 1'b1;
         end
      end else begin
         latch_in = latch_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         latch_ff          <= '0;
         regs_ff.atten     <= {4{ATTEN_SILENT}};
         regs_ff.period    <= '0;
         regs_ff.noise_ctl <= '0;
      end else begin
         latch_ff <= latch_in;
         regs_ff  <= regs_in;
      end
   end

   assign regs = regs_ff;

endmodule

`default_nettype wire

// ===== sv/psg_tone.sv =====
// one square wave tone voice: down counter, sign and held level
`default_nettype none

module psg_tone
   import psg_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       tick,
   input  wire period_type period,
   input  wire atten_type  atten,
   output level_type       level
);

   period_type cnt_ff, cnt_in, cnt_dec;
   logic       sign_ff, sign_in;
   level_type  level_ff, level_in, lv;
   logic       reload, hold;

   always_comb begin
      cnt_dec  = (cnt_ff != '0) ? cnt_ff - 10'd1 : '0;
      reload   = (cnt_dec == '0);
      hold     = period inside {PERIOD_DC_LO, PERIOD_DC_HI};
      lv       = level_of(atten);
      cnt_in   = reload ? period : cnt_dec;
      sign_in  = sign_ff;
      level_in = level_ff;
      if (reload) begin
         if (hold) begin
            level_in = lv;
         end else begin
            sign_in  = ~sign_ff;
            level_in = sign_in ? -lv : lv;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         sign_ff  <= 1'b0;
         level_ff <= '0;
      end else if (tick) begin
         cnt_ff   <= cnt_in;
         sign_ff  <= sign_in;
         level_ff <= level_in;
      end
   end

   // level after this tick, for the mix
   assign level = tick ? level_in : level_ff;

endmodule

`default_nettype wire

// ===== sv/psg_noise.sv =====
// noise voice: rate counter and 15-bit shift register
`default_nettype none

module psg_noise
   import psg_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       tick,
   input  wire logic       reseed,
   input  wire logic [2:0] noise_ctl,
   input  wire period_type period2,
   input  wire atten_type  atten,
   output level_type       level
);

   period_type cnt_ff, cnt_in, cnt_dec;
   logic       sign_ff, sign_in;
   lfsr_type   lfsr_ff, lfsr_in;
   logic       reload, fb;

   always_comb begin
      cnt_dec = (cnt_ff != '0) ? cnt_ff - 10'd1 : '0;
      reload  = (cnt_dec == '0);
      cnt_in  = cnt_dec;
      sign_in = sign_ff;
      lfsr_in = lfsr_ff;
      fb      = noise_ctl[2] ? (lfsr_ff[0] ^ lfsr_ff[1]) : lfsr_ff[0];
      if (reload) begin
         cnt_in  = (noise_ctl[1:0] == RATE_TONE2) ? period2 : (NOISE_BASE << noise_ctl[1:0]);
         sign_in = ~sign_ff;
         if (sign_in) begin
            lfsr_in = {fb, lfsr_ff[14:1]};
         end
      end
      // level comes from the register before this tick's shift
      level = lfsr_ff[0] ? level_of(atten) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         sign_ff <= 1'b0;
         lfsr_ff <= LFSR_SEED;
      end else if (reseed) begin
         lfsr_ff <= LFSR_SEED;
      end else if (tick) begin
         cnt_ff  <= cnt_in;
         sign_ff <= sign_in;
         lfsr_ff <= lfsr_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/four_voice_tone_noise_sound_generator.sv =====
// top level: request register, voices, mixer and result register
// a request is registered on accept; when it advances out of the request register,
// a tick's sample is registered in the result register and rsp_valid rises
// throughput: one request per cycle, writes and ticks alike, when no tick is stalled
// reset: synchronous, active high; volumes silent, periods zero, lfsr 0x4000
`default_nettype none

module four_voice_tone_noise_sound_generator
   import psg_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_op,
   input  wire logic [7:0]  req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic signed [15:0] rsp_sample
);

   logic              in_valid_ff, in_valid_in;
   logic              in_op_ff;
   logic [7:0]        in_data_ff;
   logic              out_valid_ff, out_valid_in;
   logic signed [15:0] sample_ff, sample_in;
   logic              advance, do_write, do_tick, load;
   regs_type          regs;
   logic              reseed;
   level_type         lvl [4];

   always_comb begin
      advance   = in_valid_ff && (in_op_ff == OP_WRITE || !out_valid_ff || !rsp_stall);
      do_write  = advance && (in_op_ff == OP_WRITE);
      do_tick   = advance && (in_op_ff == OP_TICK);
      req_stall = in_valid_ff && !advance;
      load      = req_valid && !req_stall;
      in_valid_in = load ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      if (do_tick) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
      sample_in = 16'(lvl[0]) + 16'(lvl[1]) + 16'(lvl[2]) + 16'(lvl[3]);
   end

   psg_regs u_regs (
      .clock  (clock),
      .reset  (reset),
      .wr     (do_write),
      .data   (in_data_ff),
      .regs   (regs),
      .reseed (reseed)
   );

   for (genvar v = 0; v < NUM_TONES; v++) begin : g_tone
      psg_tone u_tone (
         .clock  (clock),
         .reset  (reset),
         .tick   (do_tick),
         .period (regs.period[v]),
         .atten  (regs.atten[v]),
         .level  (lvl[v])
      );
   end

   psg_noise u_noise (
      .clock     (clock),
      .reset     (reset),
      .tick      (do_tick),
      .reseed    (reseed),
      .noise_ctl (regs.noise_ctl),
      .period2   (regs.period[2]),
      .atten     (regs.atten[3]),
      .level     (lvl[3])
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         in_op_ff   <= req_op;
         in_data_ff <= req_data;
      end
      if (do_tick) begin
         sample_ff <= sample_in;
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_sample = sample_ff;

endmodule

`default_nettype wire

// ===== sv/psg_checker.sv =====
// port level checks of the sound generator and their bind
`default_nettype none

module psg_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_stall,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire logic signed [15:0] rsp_sample
);

   // the mix of four levels never leaves its range
   a_sample_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_sample >= -16'sd16384) && (rsp_sample <= 16'sd16384))
      else $error("sample out of range");

   // out of reset the block is empty and takes requests
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

   // a held sample stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sample))
      else $error("stalled sample changed");

   // a stall upstream only happens behind a stalled result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a stalled result");

endmodule

bind four_voice_tone_noise_sound_generator psg_checker u_psg_checker (
   .clock      (clock),
   .reset      (reset),
   .req_stall  (req_stall),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_sample (rsp_sample)
);

`default_nettype wire

// ===== tb/tb_four_voice_tone_noise_sound_generator.sv =====
// self-checking testbench of the four voice tone and noise sound generator
`timescale 1ns / 100ps

module tb_four_voice_tone_noise_sound_generator;
   import psg_pkg::*;

   localparam int NUM_DIRECTED   = 25;
   localparam int RANDOM_PER_RUN = 400;
   localparam int HOLD_CYCLES    = 400;
   localparam int SETTLE_CYCLES  = 8;

   typedef struct packed {
      logic               op;
      logic [7:0]         data;
      logic               typed;
      logic signed [15:0] sample;
   } step_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              req_valid = 1'b0;
   logic              req_stall;
   logic              req_op    = OP_WRITE;
   logic [7:0]        req_data  = 8'h00;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic signed [15:0] rsp_sample;

   int   sender_idle_pct = 0;
   int   stall_pct       = 0;
   logic hold_go         = 1'b0;
   logic hold_off        = 1'b0;
   int   mismatches      = 0;

   logic signed [15:0] expected_samples [$];

   // generator state mirror
   logic [7:0] m_latch;
   atten_type  m_atten [4];
   period_type m_period [3];
   logic [2:0] m_noise_ctl;
   period_type m_count [4];
   lfsr_type   m_lfsr;
   logic [3:0] m_sign;
   level_type  m_level [4];

   level_type volume_steps [16] = '{
      14'sd4096, 14'sd3162, 14'sd2546, 14'sd1986, 14'sd1564, 14'sd1186, 14'sd936, 14'sd712,
      14'sd540, 14'sd392, 14'sd294, 14'sd208, 14'sd140, 14'sd76, 14'sd36, 14'sd0
   };

   step_row_type directed_steps [NUM_DIRECTED] = '{
      '{OP_TICK,  8'h00, 1'b1, 16'sd0},
      '{OP_TICK,  8'h00, 1'b1, 16'sd0},
      '{OP_WRITE, 8'h80, 1'b0, 16'sd0},
      '{OP_WRITE, 8'h90, 1'b0, 16'sd0},
      '{OP_TICK,  8'h00, 1'b1, -16'sd4096},
      '{OP_TICK,  8'h00, 1'b1, 16'sd4096},
      '{OP_WRITE, 8'h81, 1'b0, 16'sd0},
      '{OP_TICK,  8'h00, 1'b1, 16'sd4096},
      '{OP_TICK,  8'h00, 1'b1, 16'sd4096},
      '{OP_WRITE, 8'h80, 1'b0, 16'sd0},
      '{OP_WRITE, 8'h01, 1'b0, 16'sd0},
      '{OP_TICK,  8'h00, 1'b0, 16'sd0},
      '{OP_TICK,  8'h00, 1'b0, 16'sd0},
      '{OP_WRITE, 8'h3f, 1'b0, 16'sd0},
      '{OP_WRITE, 8'hcf, 1'b0, 16'sd0},
      '{OP_WRITE, 8'h7f, 1'b0, 16'sd0},
      '{OP_WRITE, 8'hf0, 1'b0, 16'sd0},
      '{OP_WRITE, 8'he7, 1'b0, 16'sd0},
      '{OP_TICK,  8'hff, 1'b0, 16'sd0},
      '{OP_WRITE, 8'h04, 1'b0, 16'sd0},
      '{OP_WRITE, 8'hff, 1'b0, 16'sd0},
      '{OP_WRITE, 8'h00, 1'b0, 16'sd0},
      '{OP_TICK,  8'h00, 1'b0, 16'sd0},
      '{OP_WRITE, 8'hbf, 1'b0, 16'sd0},
      '{OP_TICK,  8'h00, 1'b0, 16'sd0}
   };

   four_voice_tone_noise_sound_generator dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_op     (req_op),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_sample (rsp_sample)
   );

   always #4 clock = ~clock;

   initial begin
      #2000000;
      $display("four_voice_tone_noise_sound_generator regression: fail");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic signed [15:0] got,
                                  input logic signed [15:0] want);
      $display("mismatch: %s, got %0d expected %0d", what, got, want);
      mismatches++;
   endtask

   task automatic clear_mirror();
      m_latch     = 8'h00;
      m_noise_ctl = 3'd0;
      m_lfsr      = LFSR_SEED;
      m_sign      = 4'h0;
      for (int i = 0; i < 4; i++) begin
         m_atten[i] = ATTEN_SILENT;
         m_count[i] = '0;
         m_level[i] = '0;
      end
      for (int i = 0; i < NUM_TONES; i++) m_period[i] = '0;
   endtask

   task automatic apply_write(input logic [7:0] d);
      logic [1:0] voice;
      if (d[7]) m_latch = d;
      voice = m_latch[6:5];
      if (m_latch[4]) begin
         m_atten[voice] = d[3:0];
      end else if (voice != VOICE_NOISE) begin
         if (d[7]) m_period[voice][3:0] = d[3:0];
         else m_period[voice][9:4] = d[5:0];
      end else begin
         m_noise_ctl = d[2:0];
         m_lfsr      = LFSR_SEED;
      end
   endtask

   function automatic logic signed [15:0] advance_tick();
      int   acc;
      logic fb;
      for (int v = 0; v < NUM_TONES; v++) begin
         if (m_count[v] != 0) m_count[v] = m_count[v] - 1'b1;
         if (m_count[v] == 0) begin
            m_count[v] = m_period[v];
            m_level[v] = volume_steps[m_atten[v]];
            if (m_period[v] != PERIOD_DC_LO && m_period[v] != PERIOD_DC_HI) begin
               m_sign[v] = ~m_sign[v];
               if (m_sign[v]) m_level[v] = -m_level[v];
            end
         end
      end
      if (m_count[3] != 0) m_count[3] = m_count[3] - 1'b1;
      m_level[3] = m_lfsr[0] ? volume_steps[m_atten[3]] : level_type'(0);
      if (m_count[3] == 0) begin
         m_count[3] = (m_noise_ctl[1:0] == RATE_TONE2) ? m_period[2]
                                                      : period_type'(NOISE_BASE << m_noise_ctl[1:0]);
         m_sign[3] = ~m_sign[3];
         if (m_sign[3]) begin
            fb     = m_noise_ctl[2] ? (m_lfsr[0] ^ m_lfsr[1]) : m_lfsr[0];
            m_lfsr = {fb, m_lfsr[14:1]};
         end
      end
      acc = int'(m_level[0]) + int'(m_level[1]) + int'(m_level[2]) + int'(m_level[3]);
      return acc[15:0];
   endfunction

   task automatic offer_request(input logic op, input logic [7:0] d, input logic has_typed,
                                input logic signed [15:0] typed_sample);
      int gap;
      logic signed [15:0] predicted;
      gap = 0;
      while ($urandom_range(99) < sender_idle_pct) gap++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op    <= op;
      req_data  <= d;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (op == OP_TICK) begin
         predicted = advance_tick();
         expected_samples.push_back(has_typed ? typed_sample : predicted);
      end else begin
         apply_write(d);
      end
   endtask

   task automatic random_request(output logic op, output logic [7:0] d);
      int pick;
      pick = $urandom_range(99);
      op   = OP_WRITE;
      if (pick < 55) begin
         op = OP_TICK;
         d  = 8'($urandom);
      end else if (pick < 70) begin
         d = {1'b1, 2'($urandom_range(2)), 1'b0, 4'($urandom)};
      end else if (pick < 78) begin
         d = {1'b0, 1'($urandom),
              ($urandom_range(3) == 0) ? 6'($urandom) : 6'($urandom_range(1))};
      end else if (pick < 88) begin
         d = {1'b1, 2'($urandom), 1'b1, 4'($urandom)};
      end else if (pick < 93) begin
         d = {3'b111, 1'b0, 4'($urandom)};
      end else begin
         d = 8'($urandom);
      end
   endtask

   task automatic random_run(input int sender_pct, input int receiver_pct);
      logic       op;
      logic [7:0] d;
      sender_idle_pct = sender_pct;
      stall_pct      <= receiver_pct;
      repeat (RANDOM_PER_RUN) begin
         random_request(op, d);
         offer_request(op, d, 1'b0, 16'sd0);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_samples.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   initial begin
      wait (hold_go);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= hold_off || ($urandom_range(99) < stall_pct);
         if (rsp_valid && !rsp_stall) begin
            if (expected_samples.size() == 0) begin
               report_mismatch("sample with no request pending", rsp_sample, 16'sd0);
            end else begin
               if (rsp_sample !== expected_samples[0])
                  report_mismatch("sample", rsp_sample, expected_samples[0]);
               void'(expected_samples.pop_front());
            end
         end
      end
   end

   initial begin
      clear_mirror();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < NUM_DIRECTED; i++)
         offer_request(directed_steps[i].op, directed_steps[i].data,
                       directed_steps[i].typed, directed_steps[i].sample);

      // long receiver hold-off while requests keep coming
      hold_go <= 1'b1;
      random_run(0, 0);
      wait_drained();
      random_run(66, 0);
      random_run(0, 66);
      random_run(27, 27);

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_samples.size() != 0)
         report_mismatch("sample never arrived", 16'sd0, expected_samples[0]);
      if (mismatches == 0)
         $display("four_voice_tone_noise_sound_generator regression: pass");
      else
         $display("four_voice_tone_noise_sound_generator regression: fail");
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/psg_pkg.sv
sv/psg_regs.sv
sv/psg_tone.sv
sv/psg_noise.sv
sv/four_voice_tone_noise_sound_generator.sv
sv/psg_checker.sv
tb/tb_four_voice_tone_noise_sound_generator.sv
